### rtl/imufsd_pkg.sv
package imufsd_pkg;

    localparam logic [15:0] ONE_G_Q12 = 16'd4096;

    localparam logic [15:0] SPIKE_THRESHOLD_RST    = 16'd2048;
    localparam logic [15:0] SETTLE_TOLERANCE_RST   = 16'd410;
    localparam logic [15:0] SETTLE_GYRO_LIMIT_RST  = 16'd160;
    localparam logic [15:0] WAIT_TIMEOUT_MS_RST    = 16'd3000;
    localparam logic [15:0] SETTLE_HOLD_MS_RST     = 16'd300;
    localparam logic [15:0] SUPPRESS_WINDOW_MS_RST = 16'd1500;

    localparam logic [2:0] REG_SPIKE_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_SETTLE_TOLERANCE   = 3'd1;
    localparam logic [2:0] REG_SETTLE_GYRO_LIMIT  = 3'd2;
    localparam logic [2:0] REG_WAIT_TIMEOUT_MS    = 3'd3;
    localparam logic [2:0] REG_SETTLE_HOLD_MS     = 3'd4;
    localparam logic [2:0] REG_SUPPRESS_WINDOW_MS = 3'd5;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TOGGLE = 1'b1
    } op_t;

    typedef struct packed {
        logic [15:0] spike_threshold;
        logic [15:0] settle_tolerance;
        logic [15:0] settle_gyro_limit;
        logic [15:0] wait_timeout_ms;
        logic [15:0] settle_hold_ms;
        logic [15:0] suppress_window_ms;
    } cfg_t;

    typedef struct packed {
        op_t                operation;
        logic [31:0]        time_ms;
        logic [15:0]        accel_magnitude;
        logic [15:0]        gyro_magnitude;
        logic signed [15:0] gravity_alignment;
    } item_t;

    typedef struct packed {
        logic        phase_waiting;
        logic        side_b;
        logic        settle_active;
        logic [31:0] wait_start_time;
        logic [31:0] settle_start_time;
        logic [31:0] suppress_end_time;
        logic        suppress_armed;
    } state_t;

    typedef struct packed {
        logic settling_now;
        logic waiting;
        logic switched;
        logic current_side;
    } result_t;

endpackage

### rtl/imufsd_core.sv
module imufsd_core (
    input  imufsd_pkg::cfg_t    cfg,
    input  imufsd_pkg::item_t   item,
    input  imufsd_pkg::state_t  state,
    output imufsd_pkg::state_t  state_next,
    output imufsd_pkg::result_t result
);
    import imufsd_pkg::*;

    logic [15:0] dev;
    logic [31:0] left;
    logic        suppress_active;
    logic [31:0] elapsed;
    logic        timed_out;
    logic        settled;
    logic [31:0] settle_base;
    logic        held;
    logic        grav_neg;
    logic        grav_pos;
    logic        flip;
    logic        switched;

    always_comb
    begin
        dev         = (item.accel_magnitude >= ONE_G_Q12)
                    ? (item.accel_magnitude - ONE_G_Q12)
                    : (ONE_G_Q12 - item.accel_magnitude);
        left        = state.suppress_end_time - item.time_ms;
        suppress_active = state.suppress_armed && (left != 32'd0) && !left[31];
        elapsed     = item.time_ms - state.wait_start_time;
        timed_out   = elapsed > {16'd0, cfg.wait_timeout_ms};
        settled     = (dev <= cfg.settle_tolerance)
                    && (item.gyro_magnitude < cfg.settle_gyro_limit);
        settle_base = state.settle_active ? state.settle_start_time : item.time_ms;
        held        = (item.time_ms - settle_base) >= {16'd0, cfg.settle_hold_ms};
        grav_neg    = item.gravity_alignment[15];
        grav_pos    = !grav_neg && (item.gravity_alignment != 16'sd0);
        flip        = state.side_b ? grav_pos : grav_neg;

        state_next = state;
        switched   = 1'b0;

        if (item.operation == OP_TOGGLE)
        begin
            state_next.side_b            = !state.side_b;
            switched                     = 1'b1;
            state_next.suppress_end_time = item.time_ms + {16'd0, cfg.suppress_window_ms};
            state_next.suppress_armed    = 1'b1;
            state_next.phase_waiting     = 1'b0;
            state_next.settle_active     = 1'b0;
        end
        else if (!state.phase_waiting)
        begin
            if ((dev > cfg.spike_threshold) && !suppress_active)
            begin
                state_next.suppress_armed  = 1'b0;
                state_next.phase_waiting   = 1'b1;
                state_next.wait_start_time = item.time_ms;
                state_next.settle_active   = 1'b0;
            end
        end
        else if (timed_out)
        begin
            state_next.phase_waiting = 1'b0;
            state_next.settle_active = 1'b0;
        end
        else if (settled)
        begin
            state_next.settle_active     = 1'b1;
            state_next.settle_start_time = settle_base;
            if (held)
            begin
                if (flip)
                begin
                    state_next.side_b = !state.side_b;
                    switched          = 1'b1;
                end
                state_next.phase_waiting = 1'b0;
                state_next.settle_active = 1'b0;
            end
        end
        else
        begin
            state_next.settle_active = 1'b0;
        end

        result.current_side = state_next.side_b;
        result.switched     = switched;
        result.waiting      = state_next.phase_waiting;
        result.settling_now = state_next.settle_active;
    end

endmodule

### rtl/imu_flip_side_detector.sv
// IMU flip side detector
//
// Input stream (s_axis): one item per handshake. tuser carries the operation
// (0 = sensor sample, 1 = manual side toggle); tdata carries time_ms, accel
// magnitude, gyro magnitude and gravity alignment. Output stream (m_axis):
// exactly one item per input item, in order, with current side, switched,
// waiting and settling flags.
//
// An accepted item lands in an input register; the detector update then runs
// from that register and loads the output register once it is free. One item
// per cycle is sustained while the receiver accepts: the state update
// is a single pass of compares and 32-bit subtractions between the two
// registers.
//
// When the receiver stalls, the result is held in the output register and
// one further item waits in the input register; s_axis_tready drops only
// when both are full. Thresholds and time windows sit in APB registers and
// may be changed while the block is idle.
// Reset clears both valid flags, returns side A in the stable phase with
// suppression disarmed, and loads the register defaults.
module imu_flip_side_detector (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // time_ms, accel_magnitude, gyro_magnitude,
                                       // gravity_alignment
    input  logic [0:0]  s_axis_tuser,  // operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // current_side, switched, waiting,
                                       // settling_now, 4 bits zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import imufsd_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            REG_SPIKE_THRESHOLD:    prdata = {16'd0, cfg_reg.spike_threshold};
            REG_SETTLE_TOLERANCE:   prdata = {16'd0, cfg_reg.settle_tolerance};
            REG_SETTLE_GYRO_LIMIT:  prdata = {16'd0, cfg_reg.settle_gyro_limit};
            REG_WAIT_TIMEOUT_MS:    prdata = {16'd0, cfg_reg.wait_timeout_ms};
            REG_SETTLE_HOLD_MS:     prdata = {16'd0, cfg_reg.settle_hold_ms};
            REG_SUPPRESS_WINDOW_MS: prdata = {16'd0, cfg_reg.suppress_window_ms};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spike_threshold    <= SPIKE_THRESHOLD_RST;
            cfg_reg.settle_tolerance   <= SETTLE_TOLERANCE_RST;
            cfg_reg.settle_gyro_limit  <= SETTLE_GYRO_LIMIT_RST;
            cfg_reg.wait_timeout_ms    <= WAIT_TIMEOUT_MS_RST;
            cfg_reg.settle_hold_ms     <= SETTLE_HOLD_MS_RST;
            cfg_reg.suppress_window_ms <= SUPPRESS_WINDOW_MS_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_SPIKE_THRESHOLD:    cfg_reg.spike_threshold    <= pwdata[15:0];
                REG_SETTLE_TOLERANCE:   cfg_reg.settle_tolerance   <= pwdata[15:0];
                REG_SETTLE_GYRO_LIMIT:  cfg_reg.settle_gyro_limit  <= pwdata[15:0];
                REG_WAIT_TIMEOUT_MS:    cfg_reg.wait_timeout_ms    <= pwdata[15:0];
                REG_SETTLE_HOLD_MS:     cfg_reg.settle_hold_ms     <= pwdata[15:0];
                REG_SUPPRESS_WINDOW_MS: cfg_reg.suppress_window_ms <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // hold the item until the output register can take its result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.operation         <= op_t'(s_axis_tuser);
            in_item_reg.time_ms           <= s_axis_tdata[31:0];
            in_item_reg.accel_magnitude   <= s_axis_tdata[47:32];
            in_item_reg.gyro_magnitude    <= s_axis_tdata[63:48];
            in_item_reg.gravity_alignment <= s_axis_tdata[79:64];
        end
    end

    imufsd_core u_core (
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg};

endmodule

### rtl/imufsd_checker.sv
module imufsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    logic side_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_seen_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            side_seen_reg <= m_axis_tdata[0];
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_settle_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
        else $error("settling reported outside the wait phase");

    a_switch_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[2])
        else $error("side switched while still waiting");

    a_side_follows_switch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[0] != side_seen_reg) == m_axis_tdata[1]))
        else $error("side change and switched flag disagree");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind imu_flip_side_detector imufsd_checker u_imufsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import imufsd_pkg::*;

    localparam int REG_COUNT            = 6;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int PRESSURE_HOLD    = 120;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int MAX_DEV          = 61439;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // time_ms, accel_magnitude, gyro_magnitude,
                                     // gravity_alignment
    logic [0:0]  s_axis_tuser = '0;  // operation

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // current_side, switched, waiting,
                                     // settling_now, 4 bits zero

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cfg_t        model_cfg = '{
        spike_threshold:    SPIKE_THRESHOLD_RST,
        settle_tolerance:   SETTLE_TOLERANCE_RST,
        settle_gyro_limit:  SETTLE_GYRO_LIMIT_RST,
        wait_timeout_ms:    WAIT_TIMEOUT_MS_RST,
        settle_hold_ms:     SETTLE_HOLD_MS_RST,
        suppress_window_ms: SUPPRESS_WINDOW_MS_RST
    };

    logic        trk_waiting = 1'b0;
    logic        trk_side_b = 1'b0;
    logic        trk_settling = 1'b0;
    logic        trk_armed = 1'b0;
    logic [31:0] trk_wait_start = '0;
    logic [31:0] trk_settle_start = '0;
    logic [31:0] trk_suppress_end = '0;

    item_t       sensor_items[$];
    result_t     expected_status[$];
    item_t       staged;
    item_t       driven_item;
    result_t     want;

    logic [31:0] now_ms = 32'hFFFF_FE00;
    int          phase_items = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          item_taken = 1'b0;

    int          tx_gap = 0;
    int          tx_stretch = 0;
    bit          tx_idle_mode = 1'b1;
    bit          tx_force_busy = 1'b0;

    int          rx_stall = 0;
    int          rx_stretch = 0;
    bit          rx_idle_mode = 1'b1;
    int          hold_req_count = 0;
    int          hold_seen = 0;

    imu_flip_side_detector DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    function automatic result_t track_side(item_t it);
        result_t     r;
        logic [15:0] dev;
        logic [31:0] left;
        logic [31:0] elapsed;
        logic        neg_side;
        logic        pos_side;
        logic        flip;
        dev = (it.accel_magnitude >= ONE_G_Q12) ? it.accel_magnitude - ONE_G_Q12
                                                 : ONE_G_Q12 - it.accel_magnitude;
        r.switched = 1'b0;
        elapsed = it.time_ms - trk_wait_start;
        if (it.operation == OP_TOGGLE)
        begin
            trk_side_b = !trk_side_b;
            r.switched = 1'b1;
            trk_suppress_end = it.time_ms + {16'd0, model_cfg.suppress_window_ms};
            trk_armed = 1'b1;
            trk_waiting = 1'b0;
            trk_settling = 1'b0;
        end
        else if (!trk_waiting)
        begin
            if (dev > model_cfg.spike_threshold)
            begin
                left = trk_suppress_end - it.time_ms;
                if (!(trk_armed && left != 32'd0 && !left[31]))
                begin
                    trk_armed = 1'b0;
                    trk_waiting = 1'b1;
                    trk_wait_start = it.time_ms;
                    trk_settling = 1'b0;
                end
            end
        end
        else if (elapsed > {16'd0, model_cfg.wait_timeout_ms})
        begin
            trk_waiting = 1'b0;
            trk_settling = 1'b0;
        end
        else if (dev <= model_cfg.settle_tolerance &&
                 it.gyro_magnitude < model_cfg.settle_gyro_limit)
        begin
            if (!trk_settling)
            begin
                trk_settling = 1'b1;
                trk_settle_start = it.time_ms;
            end
            elapsed = it.time_ms - trk_settle_start;
            if (elapsed >= {16'd0, model_cfg.settle_hold_ms})
            begin
                neg_side = it.gravity_alignment[15];
                pos_side = !neg_side && it.gravity_alignment != 16'sd0;
                flip = trk_side_b ? pos_side : neg_side;
                if (flip)
                begin
                    trk_side_b = !trk_side_b;
                    r.switched = 1'b1;
                end
                trk_waiting = 1'b0;
                trk_settling = 1'b0;
            end
        end
        else
            trk_settling = 1'b0;
        r.current_side = trk_side_b;
        r.waiting = trk_waiting;
        r.settling_now = trk_settling;
        return r;
    endfunction

    function automatic void set_model_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_SPIKE_THRESHOLD:    model_cfg.spike_threshold = val;
            REG_SETTLE_TOLERANCE:   model_cfg.settle_tolerance = val;
            REG_SETTLE_GYRO_LIMIT:  model_cfg.settle_gyro_limit = val;
            REG_WAIT_TIMEOUT_MS:    model_cfg.wait_timeout_ms = val;
            REG_SETTLE_HOLD_MS:     model_cfg.settle_hold_ms = val;
            REG_SUPPRESS_WINDOW_MS: model_cfg.suppress_window_ms = val;
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] model_reg(logic [2:0] idx);
        case (idx)
            REG_SPIKE_THRESHOLD:   return model_cfg.spike_threshold;
            REG_SETTLE_TOLERANCE:  return model_cfg.settle_tolerance;
            REG_SETTLE_GYRO_LIMIT: return model_cfg.settle_gyro_limit;
            REG_WAIT_TIMEOUT_MS:   return model_cfg.wait_timeout_ms;
            REG_SETTLE_HOLD_MS:    return model_cfg.settle_hold_ms;
            default:               return model_cfg.suppress_window_ms;
        endcase
    endfunction

    function automatic int next_gap();
        int r;
        if (!tx_idle_mode || tx_force_busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [15:0] accel_from_dev(int unsigned d);
        if (d > MAX_DEV)
            d = MAX_DEV;
        if (d <= 4096 && $urandom_range(0, 1) == 1)
            return 16'(4096 - d);
        return 16'(4096 + d);
    endfunction

    function automatic logic [15:0] spike_accel();
        int unsigned thr;
        int unsigned top;
        thr = 32'(model_cfg.spike_threshold);
        if (thr >= MAX_DEV)
            return accel_from_dev($urandom_range(0, MAX_DEV));
        top = (thr + 200 > MAX_DEV) ? MAX_DEV : thr + 200;
        if ($urandom_range(0, 1) == 1)
            return accel_from_dev($urandom_range(thr + 1, top));
        return accel_from_dev($urandom_range(thr + 1, MAX_DEV));
    endfunction

    function automatic logic [15:0] settled_accel();
        int unsigned tol;
        tol = (model_cfg.settle_tolerance > MAX_DEV) ? MAX_DEV
                                                     : 32'(model_cfg.settle_tolerance);
        if ($urandom_range(0, 3) == 0)
            return accel_from_dev(tol);
        return accel_from_dev($urandom_range(0, tol));
    endfunction

    function automatic logic [15:0] settled_gyro();
        int unsigned lim;
        lim = 32'(model_cfg.settle_gyro_limit);
        if (lim == 0)
            return 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0)
            return 16'(lim - 1);
        return 16'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [15:0] random_grav();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return 16'($urandom_range(1, 16384));
        else if (r < 18)
            return 16'(0 - $urandom_range(1, 16384));
        else if (r == 18)
            return 16'd0;
        return 16'($urandom);
    endfunction

    task automatic push_item(op_t op, logic [31:0] t, logic [15:0] accel,
                             logic [15:0] gyro, logic [15:0] grav);
        item_t it;
        it.operation = op;
        it.time_ms = t;
        it.accel_magnitude = accel;
        it.gyro_magnitude = gyro;
        it.gravity_alignment = grav;
        sensor_items.push_back(it);
        phase_items++;
    endtask

    task automatic sample_at(logic [31:0] delta, logic [15:0] accel, logic [15:0] gyro,
                             logic [15:0] grav);
        now_ms = now_ms + delta;
        push_item(OP_SAMPLE, now_ms, accel, gyro, grav);
    endtask

    task automatic toggle_at(logic [31:0] delta);
        now_ms = now_ms + delta;
        push_item(OP_TOGGLE, now_ms, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic queue_scenario();
        int          kind;
        int          n;
        logic [31:0] hold;
        logic [31:0] span;
        logic [15:0] gv;
        kind = $urandom_range(0, 99);
        gv = random_grav();
        hold = {16'd0, model_cfg.settle_hold_ms};
        if (kind < 50)
        begin
            n = $urandom_range(2, 5);
            sample_at($urandom_range(1, 50), spike_accel(), 16'($urandom), random_grav());
            sample_at($urandom_range(1, 20), settled_accel(), settled_gyro(), gv);
            for (int k = 1; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    sample_at(1, 16'($urandom),
                              16'($urandom_range(model_cfg.settle_gyro_limit, 65535)), gv);
                sample_at(hold / (n - 1) + $urandom_range(0, 2), settled_accel(),
                          settled_gyro(), gv);
            end
        end
        else if (kind < 60)
        begin
            span = {16'd0, model_cfg.wait_timeout_ms};
            sample_at($urandom_range(1, 50), spike_accel(), 16'($urandom), random_grav());
            sample_at(span / 2, 16'($urandom), 16'hFFFF, gv);
            sample_at(span / 2 + $urandom_range(0, 3), settled_accel(), settled_gyro(), gv);
        end
        else if (kind < 72)
        begin
            span = {16'd0, model_cfg.suppress_window_ms};
            toggle_at($urandom_range(1, 10));
            case ($urandom_range(0, 3))
                0:       span = span;
                1:       span = span + 1;
                default: span = $urandom_range(0, span);
            endcase
            sample_at(span, spike_accel(), 16'($urandom), random_grav());
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    now_ms = $urandom;
                else
                    now_ms = now_ms + $urandom_range(0, 500);
                push_item(($urandom_range(0, 9) == 0) ? OP_TOGGLE : OP_SAMPLE, now_ms,
                          16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic check_field(string name, logic exp_val, logic act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp_val,
                     act_val);
            mismatch_count++;
        end
    endtask

    task automatic apb_write(logic [2:0] idx, logic [15:0] val);
        logic [31:0] wd;
        wd = $urandom;
        wd[15:0] = val;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wd;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        set_model_reg(idx, val);
    endtask

    task automatic apb_read_check(logic [2:0] idx);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== model_reg(idx))
        begin
            $display("%0t: register %0d readback, expected %0d actual %0d", $time, idx,
                     model_reg(idx), prdata[15:0]);
            mismatch_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_all();
        for (int i = 0; i < REG_COUNT; i++)
            apb_read_check(3'(i));
    endtask

    task automatic write_config(logic [15:0] thr, logic [15:0] tol, logic [15:0] gyr,
                                logic [15:0] tmo, logic [15:0] hold, logic [15:0] sup);
        apb_write(REG_SPIKE_THRESHOLD, thr);
        apb_write(REG_SETTLE_TOLERANCE, tol);
        apb_write(REG_SETTLE_GYRO_LIMIT, gyr);
        apb_write(REG_WAIT_TIMEOUT_MS, tmo);
        apb_write(REG_SETTLE_HOLD_MS, hold);
        apb_write(REG_SUPPRESS_WINDOW_MS, sup);
        read_back_all();
    endtask

    task automatic fill_random();
        phase_items = 0;
        while (phase_items < RANDOM_PER_PHASE)
            queue_scenario();
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (sensor_items.size() != 0 || expected_status.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_directed();
        sample_at(0, 16'd4096, 16'd0, 16'd0);
        sample_at(5, 16'd6144, 16'd0, 16'd0);
        sample_at(5, 16'd0, 16'hFFFF, 16'hC000);
        sample_at(10, 16'd4506, 16'd159, 16'd16384);
        sample_at(300, 16'd3686, 16'd0, 16'd16384);
        sample_at(5, 16'hFFFF, 16'd0, 16'd0);
        sample_at(1, 16'd4096, 16'd160, 16'hFFFF);
        sample_at(1, 16'd4096, 16'd0, 16'hFFFF);
        sample_at(300, 16'd4096, 16'd0, 16'h8000);
        sample_at(5, 16'd8192, 16'd0, 16'd0);
        sample_at(1, 16'd4096, 16'd0, 16'd0);
        sample_at(300, 16'd4096, 16'd0, 16'd0);
        sample_at(5, 16'd0, 16'd0, 16'd0);
        sample_at(3001, 16'd4096, 16'd0, 16'h4000);
        sample_at(5, 16'd0, 16'd0, 16'd0);
        sample_at(3000, 16'd4096, 16'd0, 16'h4000);
        sample_at(1, 16'd4507, 16'd0, 16'h4000);
        toggle_at(1);
        sample_at(10, 16'd0, 16'd0, 16'd0);
        sample_at(1490, 16'd0, 16'd0, 16'd0);
        toggle_at(1);
        sample_at(1501, 16'hFFFF, 16'd0, 16'd0);
        sample_at(1, 16'd4096, 16'd0, 16'h7FFF);
        sample_at(300, 16'd4096, 16'd0, 16'h7FFF);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (tx_stretch == 0)
            begin
                tx_stretch = $urandom_range(50, 250);
                tx_idle_mode = ($urandom_range(0, 3) != 0);
            end
            else
                tx_stretch--;
            if (!s_axis_tvalid || item_taken)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sensor_items.size() > 0)
                begin
                    staged = sensor_items.pop_front();
                    driven_item <= staged;
                    s_axis_tdata <= {staged.gravity_alignment, staged.gyro_magnitude,
                                     staged.accel_magnitude, staged.time_ms};
                    s_axis_tuser <= staged.operation;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = next_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            item_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stretch == 0)
            begin
                rx_stretch = $urandom_range(50, 250);
                rx_idle_mode = ($urandom_range(0, 3) != 0);
            end
            else
                rx_stretch--;
            if (hold_seen != hold_req_count)
            begin
                hold_seen = hold_req_count;
                rx_stall = PRESSURE_HOLD;
            end
            else if (rx_stall == 0 && rx_idle_mode && $urandom_range(0, 99) < 25)
                rx_stall = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(1, 3);
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %b", $time,
                             m_axis_tdata[3:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("current_side", want.current_side, m_axis_tdata[0]);
                    check_field("switched", want.switched, m_axis_tdata[1]);
                    check_field("waiting", want.waiting, m_axis_tdata[2]);
                    check_field("settling_now", want.settling_now, m_axis_tdata[3]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_status.push_back(track_side(driven_item));
                item_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("imu_flip_side_detector regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        read_back_all();

        queue_directed();
        wait_idle();

        write_config(16'($urandom_range(1000, 3000)), 16'($urandom_range(100, 600)),
                     16'($urandom_range(50, 300)), 16'($urandom_range(500, 4000)),
                     16'($urandom_range(20, 400)), 16'($urandom_range(200, 2000)));
        fill_random();
        wait_idle();

        write_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        fill_random();
        wait_idle();

        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        fill_random();
        wait_idle();

        write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        fill_random();
        wait_idle();

        write_config(16'd0, 16'hFFFF, 16'hFFFF, 16'($urandom_range(10, 600)), 16'd0,
                     16'hFFFF);
        apb_write(3'(REG_COUNT), 16'($urandom));
        apb_write(3'(REG_COUNT + 1), 16'($urandom));
        read_back_all();
        fill_random();
        wait_idle();

        write_config(SPIKE_THRESHOLD_RST, SETTLE_TOLERANCE_RST, SETTLE_GYRO_LIMIT_RST,
                     WAIT_TIMEOUT_MS_RST, SETTLE_HOLD_MS_RST, SUPPRESS_WINDOW_MS_RST);
        tx_force_busy = 1'b1;
        hold_req_count++;
        fill_random();
        wait_idle();
        tx_force_busy = 1'b0;

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("imu_flip_side_detector regression: pass");
        else
            $display("imu_flip_side_detector regression: fail");
        $finish;
    end

endmodule
